// ===== hw/rtl/salc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative cache tag and LRU engine.
// ----------------------------------------------------------------------------
package salc_pkg;

    // access kinds carried on the input tuser
    localparam int FUNC_W = 2;
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    localparam int ADDR_W = 64;
    localparam int TAG_W  = 64;
    localparam int CNT_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_SB_W   = 3;
    localparam int CFG_WAYS_W = 4;
    localparam int CFG_OFF_W  = 6;
    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd2;

    // result layout: was_hit, was_evict, hit, miss and eviction totals
    localparam int OUT_W       = 2 + 3 * CNT_W;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

    typedef struct packed {
        logic load;    // capture an accepted transaction
        logic read;    // read the set row from the tag ram
        logic commit;  // write back the row, update totals, load the result
    } t_cmd;

    typedef struct packed {
        logic out_busy;  // result register full and not taken this cycle
    } t_sts;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                  input logic [1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, v} + (CNT_W + 1)'(inc);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/salc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port ram, one write and one registered read port.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/salc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_ctrl
// Controller: sequences capture, tag ram read and write-back of each access.
// ----------------------------------------------------------------------------
module salc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  salc_pkg::t_sts i_sts,
    output salc_pkg::t_cmd o_cmd,
    output logic           o_s_ready
);
    import salc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_UPDATE;
            end
            S_UPDATE: begin
                // the next transaction may enter as this one retires
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    o_s_ready    = 1'b1;
                    if (i_s_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/salc_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_dpath
// Datapath: address split, set row lookup, lru update, totals and result.
// ----------------------------------------------------------------------------
module salc_dpath #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [salc_pkg::ADDR_W-1:0]      i_s_data,
    input  logic [salc_pkg::FUNC_W-1:0]      i_s_user,
    input  salc_pkg::t_cmd                   i_cmd,
    output salc_pkg::t_sts                   o_sts,
    output logic                             o_m_valid,
    input  logic                             i_m_ready,
    output logic [salc_pkg::OUT_TDATA_W-1:0] o_m_data
);
    import salc_pkg::*;

    localparam int SIW  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int SETS = 1 << SIW;
    localparam int WIW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW  = CFG_WAYS_W + 1;
    localparam logic [WIW-1:0] RANK_MAX = WIW'(MAX_WAYS - 1);

    typedef struct packed {
        logic             vld;
        logic [TAG_W-1:0] tag;
        logic [WIW-1:0]   rank;  // 0 is most recently used
    } t_line;

    localparam int ROW_W = MAX_WAYS * $bits(t_line);

    logic [CFG_SB_W-1:0]   r_cfg_sb;
    logic [CFG_WAYS_W-1:0] r_cfg_ways;
    logic [CFG_OFF_W-1:0]  r_cfg_off;

    logic [FUNC_W-1:0] r_func;
    logic [TAG_W-1:0]  r_tag;
    logic [SIW-1:0]    r_set;
    logic              r_rowv;
    logic [SETS-1:0]   r_row_vld;

    logic [CNT_W-1:0] r_hits;
    logic [CNT_W-1:0] r_misses;
    logic [CNT_W-1:0] r_evicts;
    logic             r_o_hit;
    logic             r_o_ev;
    logic             r_ovalid;

    logic [CFG_SB_W-1:0]  sb_eff;
    logic [WCW-1:0]       ways_eff;
    logic [ADDR_W-1:0]    shifted;
    logic [SIW-1:0]       set_n;
    logic [TAG_W-1:0]     tag_n;

    logic [ROW_W-1:0]            ram_rdata;
    t_line [MAX_WAYS-1:0]        row;
    t_line [MAX_WAYS-1:0]        row_n;
    logic  [MAX_WAYS-1:0]        in_use;

    logic           hit_f, free_f, old_f;
    logic [WIW-1:0] hit_w, free_w, old_w, old_r;
    logic [WIW-1:0] vic_w, lim;
    logic           age_all;
    logic           func_ok;
    logic [1:0]     hit_inc;
    logic           miss_inc, ev_inc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sb   <= '0;
            r_cfg_ways <= CFG_WAYS_W'(1);
            r_cfg_off  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SET_BITS:    r_cfg_sb   <= i_cfg_wdata[CFG_SB_W-1:0];
                REG_WAYS_IN_USE: r_cfg_ways <= i_cfg_wdata[CFG_WAYS_W-1:0];
                REG_OFFSET_BITS: r_cfg_off  <= i_cfg_wdata[CFG_OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sb_eff = (32'(r_cfg_sb) > MAX_SET_BITS) ? CFG_SB_W'(MAX_SET_BITS) : r_cfg_sb;
        if (r_cfg_ways == '0) begin
            ways_eff = WCW'(1);
        end else if (WCW'(r_cfg_ways) > WCW'(MAX_WAYS)) begin
            ways_eff = WCW'(MAX_WAYS);
        end else begin
            ways_eff = WCW'(r_cfg_ways);
        end
        for (int k = 0; k < MAX_WAYS; k++) begin
            in_use[k] = WCW'(k) < ways_eff;
        end
    end

    // address split at capture
    assign shifted = i_s_data >> r_cfg_off;
    assign set_n   = shifted[SIW-1:0] & ~({SIW{1'b1}} << sb_eff);
    assign tag_n   = shifted >> sb_eff;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_s_user;
            r_tag  <= tag_n;
            r_set  <= set_n;
        end
        if (i_cmd.read) begin
            r_rowv <= r_row_vld[r_set];
        end
    end

    // a row never written reads as all ways invalid
    always_comb begin
        row = ram_rdata;
        if (!r_rowv) begin
            for (int k = 0; k < MAX_WAYS; k++) begin
                row[k].vld = 1'b0;
            end
        end
    end

    // parallel tag compare, free way and oldest way search
    always_comb begin
        hit_f  = 1'b0;
        free_f = 1'b0;
        old_f  = 1'b0;
        hit_w  = '0;
        free_w = '0;
        old_w  = '0;
        old_r  = '0;
        for (int k = 0; k < MAX_WAYS; k++) begin
            if (in_use[k]) begin
                if (row[k].vld) begin
                    if (!hit_f && row[k].tag == r_tag) begin
                        hit_f = 1'b1;
                        hit_w = WIW'(k);
                    end
                    if (!old_f || row[k].rank > old_r) begin
                        old_f = 1'b1;
                        old_w = WIW'(k);
                        old_r = row[k].rank;
                    end
                end else begin
                    free_f = 1'b1;
                    free_w = WIW'(k);
                end
            end
        end
    end

    always_comb begin
        age_all = 1'b0;
        if (hit_f) begin
            vic_w = hit_w;
            lim   = row[hit_w].rank;
        end else if (free_f) begin
            vic_w   = free_w;
            lim     = RANK_MAX;
            age_all = 1'b1;
        end else begin
            vic_w = old_w;
            lim   = old_r;
        end
        for (int k = 0; k < MAX_WAYS; k++) begin
            row_n[k] = row[k];
            if (WIW'(k) == vic_w) begin
                row_n[k].vld  = 1'b1;
                row_n[k].tag  = r_tag;
                row_n[k].rank = '0;
            end else if (in_use[k] && row[k].vld && (age_all || row[k].rank < lim)
                         && row[k].rank != RANK_MAX) begin
                row_n[k].rank = row[k].rank + WIW'(1);
            end
        end
    end

    assign func_ok = (r_func == FUNC_LOAD) || (r_func == FUNC_STORE) ||
                     (r_func == FUNC_MODIFY);

    // the store half of a modify always hits and leaves the ranks alone
    always_comb begin
        hit_inc  = 2'd0;
        miss_inc = 1'b0;
        ev_inc   = 1'b0;
        if (func_ok) begin
            hit_inc  = {1'b0, hit_f} + ((r_func == FUNC_MODIFY) ? 2'd1 : 2'd0);
            miss_inc = !hit_f;
            ev_inc   = !hit_f && !free_f;
        end
    end

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && func_ok),
        .i_waddr (r_set),
        .i_wdata (row_n),
        .i_re    (i_cmd.read),
        .i_raddr (r_set),
        .o_rdata (ram_rdata)
    );

    // totals double as the result fields: no commit while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (func_ok) begin
                    r_row_vld[r_set] <= 1'b1;
                end
                r_hits   <= sat_add(r_hits, hit_inc);
                r_misses <= sat_add(r_misses, {1'b0, miss_inc});
                r_evicts <= sat_add(r_evicts, {1'b0, ev_inc});
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_hit <= func_ok && hit_f;
            r_o_ev  <= ev_inc;
        end
    end

    assign o_sts.out_busy = r_ovalid && !i_m_ready;
    assign o_m_valid      = r_ovalid;
    assign o_m_data       = {{OUT_PAD_W{1'b0}}, r_evicts, r_misses, r_hits,
                             r_o_ev, r_o_hit};

endmodule

// ===== hw/rtl/set_assoc_lru_cache_tags.sv =====
`timescale 1ns / 1ps
// timing: a transaction is captured, its set row read from the tag ram, then the
//   row written back with the totals and result register; a new transaction is
//   taken only while idle or as the last retires; a waiting result stalls the write-back
// reset: synchronous, active low; clears the per-set valid flags at once (no
//   clearing pass), the hit, miss and eviction totals, and restores the config
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag lookup and LRU replacement engine of a set-associative cache.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [salc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // address[63:0]
    input  logic [salc_pkg::ADDR_W-1:0]      i_s_axis_tdata,
    // func[1:0]
    input  logic [salc_pkg::FUNC_W-1:0]      i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // was_hit[0], was_evict[1], hit_total[33:2], miss_total[65:34],
    // evict_total[97:66], zero pad[103:98]
    output logic [salc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import salc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    salc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_s_ready (o_s_axis_tready)
    );

    salc_dpath #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_m_data    (o_m_axis_tdata)
    );

    // a captured transaction always reads its set row next
    a_load_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.read)
        else $error("set row not read after capture");

    // write-back never overwrites a result still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !sts.out_busy)
        else $error("commit while result register busy");

    // one access cannot both hit and evict
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]))
        else $error("hit and eviction flagged together");

    // hit total never goes down
    a_hits_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_m_axis_tdata[33:2] >= $past(o_m_axis_tdata[33:2]))
        else $error("hit total decreased");

endmodule
